### rtl/spr_pkg.sv
package spr_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int MAX_ENTRIES = 256;
  localparam int MAX_REC     = 16;
  localparam int SLOT_AW     = 6;
  localparam int ENT_AW      = 8;
  localparam int STG_AW      = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] CAP_RESET = 16'd4096;
  localparam logic [2:0]  REG_CAP   = 3'd0;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_UPD  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_UPD_LONG  = 3'd3,
    ST_REC_LONG  = 3'd4
  } status_t;

  // Classified command handed from the front to the back
  typedef enum logic [2:0] {
    K_STAGE = 3'd0,
    K_ADD   = 3'd1,
    K_UPD   = 3'd2,
    K_DEL   = 3'd3,
    K_READ  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] key;
    logic [15:0] bytes;
    logic [31:0] word;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] word;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] key;
    logic [4:0]  len;
    logic [7:0]  start;
    logic [15:0] bytes;
  } slot_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_BS,
    S_BS_CMP,
    S_FIND,
    S_SHIFT,
    S_SHIFT_WR,
    S_COPY_RD,
    S_COPY_WR,
    S_CMP_RD,
    S_CMP_WR,
    S_REB_RD,
    S_REB_WR,
    S_DSH_RD,
    S_DSH_WR,
    S_RD_RD,
    S_RD_EMIT,
    S_EMIT
  } state_t;

endpackage

### rtl/spr_front.sv
module spr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    opcode,
  input  logic [31:0]   record_key,
  input  logic [15:0]   record_bytes,
  input  logic [31:0]   entry_word,
  input  logic          entry_last,
  input  logic          cmd_pop,
  output logic          cmd_empty,
  output spr_pkg::cmd_t cmd
);
  import spr_pkg::*;

  cmd_t        q [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  cmd_t        cls;
  logic        do_push;
  logic        do_pop;

  // Classify the incoming transaction
  always_comb begin
    cls.key   = record_key;
    cls.bytes = record_bytes;
    cls.word  = entry_word;
    case (opcode)
      OP_ADD:  cls.kind = entry_last ? K_ADD : K_STAGE;
      OP_UPD:  cls.kind = entry_last ? K_UPD : K_STAGE;
      OP_DEL:  cls.kind = K_DEL;
      default: cls.kind = K_READ;
    endcase
  end

  assign full      = (count == 2'(QUEUE_DEPTH));
  assign cmd_empty = (count == 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && !cmd_empty;

  // Command queue towards the back
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### rtl/spr_outq.sv
module spr_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_push,
  input  spr_pkg::res_t res_d,
  output logic          res_full,
  input  logic          pop,
  output logic          empty,
  output spr_pkg::res_t res_q
);
  import spr_pkg::*;

  res_t       q [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'(QUEUE_DEPTH));
  assign empty    = (count == 2'd0);
  assign res_q    = q[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // Result queue
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= res_d;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### rtl/spr_back.sv
module spr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [15:0]   byte_capacity,
  input  logic          cmd_empty,
  input  spr_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output spr_pkg::res_t res_d
);
  import spr_pkg::*;

  // Storage
  slot_t       slot_mem  [MAX_SLOTS];
  logic [31:0] entry_mem [MAX_ENTRIES];
  logic [31:0] stg_mem   [MAX_REC];

  logic               slot_we;
  logic [SLOT_AW-1:0] slot_wa, slot_ra;
  slot_t              slot_wd, slot_rd;
  logic               ent_we;
  logic [ENT_AW-1:0]  ent_wa, ent_ra;
  logic [31:0]        ent_wd, ent_rd;
  logic               stg_we;
  logic [STG_AW-1:0]  stg_wa, stg_ra;
  logic [31:0]        stg_rd;

  state_t      state, state_next;
  cmd_t        cmd_r;
  logic [4:0]  sc;
  logic [6:0]  rc;
  logic [8:0]  ec;
  logic [15:0] used;
  logic [6:0]  lo, hi, mid_r;
  logic [4:0]  len_r;
  logic [4:0]  dlen;
  logic [7:0]  s_start;
  logic [8:0]  i_r;
  logic [8:0]  cbase;
  status_t     status_r;
  logic        rd_oob;

  logic [4:0]  sc_inc;
  logic [6:0]  mid;
  logic        add_fail;
  logic [9:0]  copy_pos;
  logic [9:0]  cmp_src;
  logic [9:0]  rd_pos;
  logic        found;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (ent_we) entry_mem[ent_wa] <= ent_wd;
    ent_rd <= entry_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (stg_we) stg_mem[stg_wa] <= cmd_r.word;
    stg_rd <= stg_mem[stg_ra];
  end

  // Shared arithmetic
  assign sc_inc   = (sc < 5'(MAX_REC)) ? sc + 5'd1 : 5'(MAX_REC + 1);
  assign mid      = lo + ((hi - lo) >> 1);
  assign add_fail = ({1'b0, used} + {1'b0, cmd_r.bytes} > {1'b0, byte_capacity})
                 || (rc >= 7'(MAX_SLOTS))
                 || ({1'b0, ec} + 10'(sc_inc) > 10'(MAX_ENTRIES));
  assign copy_pos = {1'b0, cbase} + {1'b0, i_r};
  assign cmp_src  = {1'b0, i_r} + 10'(dlen);
  assign rd_pos   = 10'(s_start) + {1'b0, i_r};
  assign found    = (lo < rc) && (slot_rd.key == cmd_r.key);

  // Next state and storage ports
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    slot_we    = 1'b0;
    slot_wa    = i_r[SLOT_AW-1:0];
    slot_wd    = slot_rd;
    slot_ra    = i_r[SLOT_AW-1:0];
    ent_we     = 1'b0;
    ent_wa     = i_r[ENT_AW-1:0];
    ent_wd     = ent_rd;
    ent_ra     = cmp_src[ENT_AW-1:0];
    stg_we     = 1'b0;
    stg_wa     = sc[STG_AW-1:0];
    stg_ra     = i_r[STG_AW-1:0];
    res_push   = 1'b0;
    res_d      = '{status: status_r, word: 32'd0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (cmd_r.kind == K_STAGE || cmd_r.kind == K_ADD || cmd_r.kind == K_UPD) begin
          stg_we = (sc < 5'(MAX_REC));
        end
        case (cmd_r.kind)
          K_STAGE: state_next = S_IDLE;
          K_ADD:   state_next = (sc_inc > 5'(MAX_REC) || add_fail) ? S_EMIT : S_BS;
          K_UPD:   state_next = (sc_inc > 5'(MAX_REC)) ? S_EMIT : S_BS;
          default: state_next = S_BS;
        endcase
      end
      // lower-bound search, each probe passing through S_BS and then S_BS_CMP
      S_BS: begin
        if (lo < hi) begin
          slot_ra    = mid[SLOT_AW-1:0];
          state_next = S_BS_CMP;
        end else if (cmd_r.kind == K_ADD) begin
          state_next = S_SHIFT;
        end else begin
          slot_ra    = lo[SLOT_AW-1:0];
          state_next = S_FIND;
        end
      end
      S_BS_CMP: state_next = S_BS;
      S_FIND: begin
        if (!found) begin
          state_next = S_EMIT;
        end else begin
          case (cmd_r.kind)
            K_UPD:   state_next = (slot_rd.len < len_r) ? S_EMIT : S_COPY_RD;
            K_DEL:   state_next = S_CMP_RD;
            K_READ:  state_next = (slot_rd.len == 5'd0) ? S_EMIT : S_RD_RD;
            default: state_next = S_EMIT;
          endcase
        end
      end
      // open a hole in the directory for the new slot
      S_SHIFT: begin
        if (i_r > {2'b0, lo}) begin
          slot_ra    = SLOT_AW'(i_r - 9'd1);
          state_next = S_SHIFT_WR;
        end else begin
          slot_we    = 1'b1;
          slot_wa    = lo[SLOT_AW-1:0];
          slot_wd    = '{key: cmd_r.key, len: len_r, start: ec[7:0], bytes: cmd_r.bytes};
          state_next = S_COPY_RD;
        end
      end
      // i_r already points at the source slot; the copy lands one above it
      S_SHIFT_WR: begin
        slot_we    = 1'b1;
        slot_wa    = SLOT_AW'(i_r + 9'd1);
        state_next = S_SHIFT;
      end
      // staged words into the entry store
      S_COPY_RD: begin
        state_next = (i_r < 9'(len_r)) ? S_COPY_WR : S_EMIT;
      end
      S_COPY_WR: begin
        ent_we     = (copy_pos < 10'(MAX_ENTRIES));
        ent_wa     = copy_pos[ENT_AW-1:0];
        ent_wd     = stg_rd;
        state_next = S_COPY_RD;
      end
      // compaction of the entry store
      S_CMP_RD: begin
        state_next = (cmp_src < {1'b0, ec}) ? S_CMP_WR : S_REB_RD;
      end
      S_CMP_WR: begin
        ent_we     = 1'b1;
        state_next = S_CMP_RD;
      end
      // rebase later start indices
      S_REB_RD: begin
        state_next = (i_r < 9'(rc)) ? S_REB_WR : S_DSH_RD;
      end
      S_REB_WR: begin
        slot_we       = (i_r[SLOT_AW-1:0] != lo[SLOT_AW-1:0]) && (slot_rd.start > s_start);
        slot_wd.start = slot_rd.start - 8'(dlen);
        state_next    = S_REB_RD;
      end
      // close the gap in the directory
      S_DSH_RD: begin
        slot_ra    = SLOT_AW'(i_r + 9'd1);
        state_next = (i_r + 9'd1 < 9'(rc)) ? S_DSH_WR : S_EMIT;
      end
      S_DSH_WR: begin
        slot_we    = 1'b1;
        state_next = S_DSH_RD;
      end
      // stream entries out
      S_RD_RD: begin
        ent_ra     = rd_pos[ENT_AW-1:0];
        state_next = S_RD_EMIT;
      end
      // keep the read address so the word holds while the result queue is full
      S_RD_EMIT: begin
        ent_ra = rd_pos[ENT_AW-1:0];
        res_d  = '{status: ST_OK, word: (rd_oob ? 32'd0 : ent_rd),
                   last: (i_r + 9'd1 == 9'(len_r))};
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = (i_r + 9'd1 == 9'(len_r)) ? S_IDLE : S_RD_RD;
        end
      end
      S_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sc    <= 5'd0;
      rc    <= 7'd0;
      ec    <= 9'd0;
      used  <= 16'd0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (!cmd_empty) cmd_r <= cmd;
        end
        S_DECODE: begin
          lo       <= 7'd0;
          hi       <= rc;
          i_r      <= {2'b0, rc};
          status_r <= ST_NOT_FOUND;
          case (cmd_r.kind)
            K_STAGE: sc <= sc_inc;
            K_ADD, K_UPD: begin
              sc    <= 5'd0;
              len_r <= sc_inc;
              if (sc_inc > 5'(MAX_REC)) status_r <= ST_REC_LONG;
              else if (cmd_r.kind == K_ADD && add_fail) status_r <= ST_NO_SPACE;
            end
            default: ;
          endcase
        end
        S_BS: begin
          mid_r <= mid;
        end
        S_BS_CMP: begin
          if (slot_rd.key < cmd_r.key) lo <= mid_r + 7'd1;
          else hi <= mid_r;
        end
        S_FIND: begin
          s_start  <= slot_rd.start;
          cbase    <= {1'b0, slot_rd.start};
          dlen     <= ({4'b0, slot_rd.len} > ec) ? ec[4:0] : slot_rd.len;
          status_r <= found ? ST_OK : ST_NOT_FOUND;
          i_r      <= (cmd_r.kind == K_DEL) ? {1'b0, slot_rd.start} : 9'd0;
          if (found && cmd_r.kind == K_UPD && slot_rd.len < len_r) status_r <= ST_UPD_LONG;
          if (found && cmd_r.kind == K_DEL) used <= used - slot_rd.bytes;
          if (cmd_r.kind == K_READ) begin
            len_r <= (slot_rd.len > 5'(MAX_REC)) ? 5'(MAX_REC) : slot_rd.len;
          end
        end
        S_SHIFT: begin
          if (i_r > {2'b0, lo}) begin
            i_r <= i_r - 9'd1;
          end else begin
            i_r   <= 9'd0;
            cbase <= ec;
          end
        end
        S_COPY_RD: begin
          if (!(i_r < 9'(len_r))) begin
            status_r <= ST_OK;
            if (cmd_r.kind == K_ADD) begin
              rc   <= rc + 7'd1;
              ec   <= ec + 9'(len_r);
              used <= used + cmd_r.bytes;
            end
          end
        end
        S_COPY_WR, S_CMP_WR, S_REB_WR, S_DSH_WR: i_r <= i_r + 9'd1;
        S_CMP_RD: begin
          if (!(cmp_src < {1'b0, ec})) i_r <= 9'd0;
        end
        S_REB_RD: begin
          if (!(i_r < 9'(rc))) i_r <= {3'b0, lo[SLOT_AW-1:0]};
        end
        S_DSH_RD: begin
          if (!(i_r + 9'd1 < 9'(rc))) begin
            rc       <= rc - 7'd1;
            ec       <= ec - 9'(dlen);
            status_r <= ST_OK;
          end
        end
        S_RD_RD: begin
          rd_oob <= (rd_pos >= 10'(MAX_ENTRIES));
        end
        S_RD_EMIT: begin
          if (!res_full) i_r <= i_r + 9'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/slotted_page_record_store.sv
// Channel   Handshake              Payload
// input     push / full            opcode, record_key, record_bytes, entry_word, entry_last
// result    pop / empty            status, read_word, result_last
// config    psel/penable/pwrite    paddr, pwdata, prdata (byte_capacity at 0)
//
// A two-entry command queue parts the front from the back, which runs one command
// at a time. A staging word passes the back through S_IDLE and S_DECODE; a commit
// or lookup takes a read and a compare state per binary-search probe plus a read
// and a write state per slot moved and per entry copied, so a delete scales with live
// entries and slots. Reset clears the counts and queues; the storage needs no clearing
// pass. A full result queue stalls the back and, via the command queue, the input.
module slotted_page_record_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [31:0] record_key,
  input  logic [15:0] record_bytes,
  input  logic [31:0] entry_word,
  input  logic        entry_last,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [31:0] read_word,
  output logic        result_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import spr_pkg::*;

  logic [15:0] byte_capacity;
  logic        cmd_empty;
  logic        cmd_pop;
  cmd_t        cmd;
  logic        res_full;
  logic        res_push;
  res_t        res_d;
  res_t        res_q;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_CAP) ? {16'd0, byte_capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_CAP) begin
      byte_capacity <= pwdata[15:0];
    end
  end

  spr_front u_front (
    .clk, .rst, .push, .full, .opcode, .record_key, .record_bytes,
    .entry_word, .entry_last, .cmd_pop, .cmd_empty, .cmd
  );

  spr_back u_back (
    .clk, .rst, .byte_capacity, .cmd_empty, .cmd, .cmd_pop,
    .res_full, .res_push, .res_d
  );

  spr_outq u_outq (
    .clk, .rst, .res_push, .res_d, .res_full, .pop, .empty, .res_q
  );

  assign status      = res_q.status;
  assign read_word   = res_q.word;
  assign result_last = res_q.last;

endmodule

### tb/slotted_page_record_store_tb.sv
`timescale 1ns / 100ps

module slotted_page_record_store_tb;
  import spr_pkg::*;

  // Page model: directory and entry store as the block should hold them
  class page_scoreboard;
    logic [31:0] keys[MAX_SLOTS];
    int          lens[MAX_SLOTS];
    int          starts[MAX_SLOTS];
    logic [15:0] sizes[MAX_SLOTS];
    logic [31:0] store[MAX_ENTRIES];
    logic [31:0] staged[MAX_REC];
    int          n_recs, n_ents, n_staged;
    logic [15:0] used, capacity;
    res_t        pending[$];
    int          errors;

    function new();
      n_recs = 0; n_ents = 0; n_staged = 0; used = 0; capacity = CAP_RESET; errors = 0;
    endfunction

    function int lower_bound(logic [31:0] key);
      int lo, hi, mid;
      lo = 0; hi = n_recs;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (keys[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return lo;
    endfunction

    function int find(logic [31:0] key);
      int i;
      i = lower_bound(key);
      if (i >= n_recs || keys[i] != key) return -1;
      return i;
    endfunction

    function void answer(status_t st, logic [31:0] w, logic l);
      res_t r;
      r.status = st; r.word = w; r.last = l;
      pending.push_back(r);
    endfunction

    function status_t add_rec(logic [31:0] key, logic [15:0] b, int len);
      int i, at;
      if (int'(used) + int'(b) > int'(capacity)) return ST_NO_SPACE;
      if (n_recs >= MAX_SLOTS || n_ents + len > MAX_ENTRIES) return ST_NO_SPACE;
      at = lower_bound(key);
      for (i = n_recs; i > at; i--) begin
        keys[i] = keys[i-1]; lens[i] = lens[i-1]; starts[i] = starts[i-1]; sizes[i] = sizes[i-1];
      end
      keys[at] = key; lens[at] = len; starts[at] = n_ents; sizes[at] = b;
      n_recs++;
      for (i = 0; i < len; i++) store[n_ents++] = staged[i];
      used = used + b;
      return ST_OK;
    endfunction

    function status_t del_rec(logic [31:0] key);
      int at, i, s, len;
      at = find(key);
      if (at < 0) return ST_NOT_FOUND;
      s = starts[at]; len = lens[at];
      used = used - sizes[at];
      for (i = s; i + len < n_ents; i++) store[i] = store[i+len];
      for (i = 0; i < n_recs; i++) if (i != at && starts[i] > s) starts[i] -= len;
      n_ents -= len;
      for (i = at; i + 1 < n_recs; i++) begin
        keys[i] = keys[i+1]; lens[i] = lens[i+1]; starts[i] = starts[i+1]; sizes[i] = sizes[i+1];
      end
      n_recs--;
      return ST_OK;
    endfunction

    function status_t upd_rec(logic [31:0] key, int len);
      int at, i;
      at = find(key);
      if (at < 0) return ST_NOT_FOUND;
      if (lens[at] < len) return ST_UPD_LONG;
      for (i = 0; i < len; i++) store[starts[at]+i] = staged[i];
      return ST_OK;
    endfunction

    // Accepted input transaction
    function void note_input(op_t op, logic [31:0] key, logic [15:0] b, logic [31:0] w,
                             logic l);
      int len, at, i;
      status_t st;
      if (op == OP_ADD || op == OP_UPD) begin
        if (n_staged < MAX_REC) staged[n_staged++] = w;
        else n_staged = MAX_REC + 1;
        if (!l) return;
        len = n_staged; n_staged = 0;
        if (len > MAX_REC) st = ST_REC_LONG;
        else if (op == OP_ADD) st = add_rec(key, b, len);
        else st = upd_rec(key, len);
        answer(st, 0, 1);
      end else if (op == OP_DEL) begin
        answer(del_rec(key), 0, 1);
      end else begin
        at = find(key);
        if (at < 0) answer(ST_NOT_FOUND, 0, 1);
        else if (lens[at] == 0) answer(ST_OK, 0, 1);
        else for (i = 0; i < lens[at]; i++)
          answer(ST_OK, store[starts[at]+i], i + 1 == lens[at]);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [2:0] st, logic [31:0] w, logic l);
      res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result st=%0d word=%h last=%0b", st, w, l));
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) report($sformatf("status %0d, want %0d", st, e.status));
      if (w !== e.word) report($sformatf("read_word %h, want %h", w, e.word));
      if (l !== e.last) report($sformatf("result_last %0b, want %0b", l, e.last));
    endtask
  endclass

  logic        clk = 0, rst = 1;
  logic        push = 0, pop = 0;
  logic        full, empty;
  logic [1:0]  opcode = 0;
  logic [31:0] record_key = 0, entry_word = 0;
  logic [15:0] record_bytes = 0;
  logic        entry_last = 0;
  logic [2:0]  status;
  logic [31:0] read_word, prdata;
  logic        result_last, pready;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;

  page_scoreboard page = new();
  int  cycles = 0;
  int  hold_off = 0;
  bit  finishing = 0;
  logic [31:0] used_keys[$];
  logic [15:0] n_phase_caps[5] = '{16'hFFFF, 16'd600, 16'd0, 16'd4096, 16'hFFFF};

  slotted_page_record_store u_top (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Input monitor
  always @(posedge clk)
    if (!rst && push && !full)
      page.note_input(op_t'(opcode), record_key, record_bytes, entry_word, entry_last);

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst && pop && !empty) page.check_result(status, read_word, result_last);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 0;
    end else if (finishing || $urandom_range(0, 9) < 7) pop <= 1;
    else pop <= 0;
  end

  // Idle gap on the input side; push drops only while waiting
  task automatic gap();
    int n;
    if ($urandom_range(0, 3) != 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    push <= 0;
    repeat (n) @(posedge clk);
  endtask

  // One input transaction; push stays high for a following transaction
  task automatic send(op_t op, logic [31:0] key, logic [15:0] b, logic [31:0] w, logic l);
    push <= 1; opcode <= op; record_key <= key; record_bytes <= b;
    entry_word <= w; entry_last <= l;
    do @(posedge clk); while (full);
  endtask

  task automatic send_run(op_t op, logic [31:0] key, logic [15:0] b, int len);
    int i;
    for (i = 0; i < len; i++) begin
      send(op, key, b, $urandom, i == len - 1);
      gap();
    end
  endtask

  task automatic cfg_write(logic [15:0] cap);
    psel <= 1; pwrite <= 1; paddr <= 3'(4 * REG_CAP); pwdata <= {16'h0, cap};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    page.capacity = cap;
  endtask

  task automatic drain();
    push <= 0;
    while (page.pending.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    pick_key = ($urandom_range(0, 1)) ? $urandom_range(0, 40) : $urandom;
    used_keys.push_back(pick_key);
  endfunction

  initial begin
    int n, i;
    op_t op;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, equal keys, overlong, no space, interleaving
    send_run(OP_ADD, 32'h0, 16'h0, 1);
    send_run(OP_ADD, 32'hFFFF_FFFF, 16'd100, MAX_REC);
    send_run(OP_ADD, 32'd5, 16'd10, 2);
    send_run(OP_ADD, 32'd5, 16'd20, 3);
    send(OP_READ, 32'd5, 0, 0, 0);
    send_run(OP_ADD, 32'd7, 16'hFFFF, 1);
    send_run(OP_ADD, 32'd8, 16'd1, MAX_REC + 2);
    send_run(OP_UPD, 32'hFFFF_FFFF, 0, 2);
    send_run(OP_UPD, 32'd0, 0, 4);
    send_run(OP_UPD, 32'd99, 0, 1);
    send(OP_ADD, 32'd9, 16'd1, 32'hFFFF_FFFF, 0);
    send(OP_READ, 32'hFFFF_FFFF, 0, 0, 1);
    send(OP_DEL, 32'd5, 0, 0, 1);
    send(OP_ADD, 32'd9, 16'd1, 32'hA5A5_5A5A, 1);
    send(OP_READ, 32'd5, 0, 0, 0);
    send(OP_READ, 32'd9, 0, 0, 0);
    send(OP_DEL, 32'd1234, 0, 0, 0);
    send(OP_READ, 32'd0, 0, 0, 0);
    drain();

    // Random phases across capacity settings
    foreach (n_phase_caps[p]) begin
      cfg_write(n_phase_caps[p]);
      if (p == 1) hold_off = 400;
      for (n = 0; n < 12; n++) begin
        op = op_t'($urandom_range(0, 3));
        if (op == OP_ADD || op == OP_UPD) begin
          i = ($urandom_range(0, 15) == 0) ? MAX_REC + 1 : $urandom_range(1, 6);
          if ($urandom_range(0, 7) == 0) i = MAX_REC;
          send_run(op, pick_key(),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200)), i);
        end else begin
          send(op, pick_key(), 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
        end
        gap();
      end
      drain();
    end

    finishing = 1;
    drain();
    if (page.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### files.f
rtl/spr_pkg.sv
rtl/spr_front.sv
rtl/spr_outq.sv
rtl/spr_back.sv
rtl/slotted_page_record_store.sv
tb/slotted_page_record_store_tb.sv
